// ----- rtl/core/psd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-segment hit distance package
// Shared constants and the control record that travels down the pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Default coordinate width of every point field.
    localparam int COORD_BITS = 16;

    // Width and reset value of the tolerance register.
    localparam int TOL_BITS = 10;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 10'd4;

    // Control record carried beside the payload of every stage.
    typedef struct packed {
        logic vld;
        logic outside;
        logic degen;
    } t_ctl;

endpackage

// ----- rtl/core/psd_root_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root step stage
// Decides one bit of q, the largest value with q*q*den <= rem0, by keeping
// the remainder rem0 - q*q*den and the running product q*den.
// ----------------------------------------------------------------------------
module psd_root_stage #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS,
    parameter int BIT        = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  psd_pkg::t_ctl              i_ctl,
    input  logic [4*COORD_BITS+3:0]    i_rem,
    input  logic [3*COORD_BITS+1:0]    i_qd,
    input  logic [2*COORD_BITS:0]      i_den,
    input  logic [COORD_BITS:0]        i_q,
    output psd_pkg::t_ctl              o_ctl,
    output logic [4*COORD_BITS+3:0]    o_rem,
    output logic [3*COORD_BITS+1:0]    o_qd,
    output logic [2*COORD_BITS:0]      o_den,
    output logic [COORD_BITS:0]        o_q
);

    localparam int RW  = 4*COORD_BITS + 4;
    localparam int QDW = 3*COORD_BITS + 2;
    localparam int QW  = COORD_BITS + 1;

    psd_pkg::t_ctl    r_ctl;
    logic [RW-1:0]    r_rem;
    logic [QDW-1:0]   r_qd;
    logic [2*COORD_BITS:0] r_den;
    logic [QW-1:0]    r_q;

    logic [RW:0]      w_sub;
    logic [RW:0]      w_diff;
    logic [RW-1:0]    n_rem;
    logic [QDW-1:0]   n_qd;
    logic [QW-1:0]    n_q;

    // Trying q + 2^BIT costs (q*den << BIT+1) + (den << 2*BIT) more.
    always_comb begin
        w_sub  = ((RW+1)'(i_qd) << (BIT+1)) + ((RW+1)'(i_den) << (2*BIT));
        w_diff = {1'b0, i_rem} - w_sub;
        if (!w_diff[RW]) begin
            n_rem = w_diff[RW-1:0];
            n_qd  = i_qd + (QDW'(i_den) << BIT);
            n_q   = i_q | (QW'(1) << BIT);
        end else begin
            n_rem = i_rem;
            n_qd  = i_qd;
            n_q   = i_q;
        end
    end

    // Control moves with the enable and clears on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_qd  <= n_qd;
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_qd  = r_qd;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

// ----- rtl/core/point_segment_hit_distance_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-segment hit distance core
// Tests a point against a segment's widened bounding box and gives the
// floored distance to the segment's line, or to the endpoint if degenerate.
// ----------------------------------------------------------------------------
//  Channel   Dir  Content
//  s_axis    in   tdata: point_x, point_y, start_x, start_y, end_x, end_y
//  m_axis    out  tdata: distance; tuser: outside_box
//  cfg       in   hit_tolerance write
//
// One transfer is taken every cycle while m_axis does not stall; the pipeline has
// five arithmetic stages and one root stage per result bit.
// Reset clears the valid bits of all stages and loads the tolerance with 4.
// A stall on m_axis freezes the whole pipeline and drops s_axis tready.
// ----------------------------------------------------------------------------
module point_segment_hit_distance_core #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // point_x, point_y, start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // distance in the lowest bits
    output logic [((COORD_BITS+8)/8)*8-1:0]   o_m_axis_tdata,
    // outside_box
    output logic                       o_m_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    input  logic                       i_cfg_we,
    input  logic [psd_pkg::TOL_BITS-1:0] i_cfg_wdata
);

    localparam int C     = COORD_BITS;
    localparam int TB    = psd_pkg::TOL_BITS;
    localparam int BW    = ((C > TB) ? C : TB) + 3;
    localparam int DW    = C + 1;
    localparam int PW    = 2*C + 2;
    localparam int MW    = 2*C + 1;
    localparam int RW    = 4*C + 4;
    localparam int QDW   = 3*C + 2;
    localparam int QW    = C + 1;
    localparam int OUT_W = ((C+8)/8)*8;
    localparam int NST   = C + 1;

    logic w_en;
    logic [TB-1:0] r_tol;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= psd_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // ---------------- stage 1: box test and differences ----------------
    logic signed [BW-1:0] w_px, w_py, w_sx, w_sy, w_ex, w_ey, w_tol;
    logic signed [BW-1:0] w_mnx, w_mxx, w_mny, w_mxy;
    psd_pkg::t_ctl n_ctl1, r_ctl1;
    logic signed [DW-1:0] r_dx, r_dy, r_ox, r_oy;

    always_comb begin
        w_px  = BW'(signed'(i_s_axis_tdata[0*C +: C]));
        w_py  = BW'(signed'(i_s_axis_tdata[1*C +: C]));
        w_sx  = BW'(signed'(i_s_axis_tdata[2*C +: C]));
        w_sy  = BW'(signed'(i_s_axis_tdata[3*C +: C]));
        w_ex  = BW'(signed'(i_s_axis_tdata[4*C +: C]));
        w_ey  = BW'(signed'(i_s_axis_tdata[5*C +: C]));
        w_tol = signed'(BW'(r_tol));
        w_mnx = (w_sx < w_ex) ? w_sx : w_ex;
        w_mxx = (w_sx < w_ex) ? w_ex : w_sx;
        w_mny = (w_sy < w_ey) ? w_sy : w_ey;
        w_mxy = (w_sy < w_ey) ? w_ey : w_sy;
        n_ctl1.vld     = i_s_axis_tvalid;
        n_ctl1.outside = (w_px < w_mnx - w_tol) || (w_px > w_mxx + w_tol) ||
                         (w_py < w_mny - w_tol) || (w_py > w_mxy + w_tol);
        n_ctl1.degen   = (w_sx == w_ex) && (w_sy == w_ey);
    end

    // ---------------- stage 2: products ----------------
    psd_pkg::t_ctl r_ctl2;
    logic signed [PW-1:0] r_dyox, r_dxoy, r_dxdx, r_dydy, r_oxox, r_oyoy;

    // ---------------- stage 3: numerator magnitude and denominator -------
    psd_pkg::t_ctl r_ctl3;
    logic signed [PW-1:0] w_n;
    logic [MW-1:0] r_mag, r_den3, r_esq3;

    assign w_n = r_dyox - r_dxoy;

    // ---------------- stage 4: split square of the numerator -------------
    psd_pkg::t_ctl r_ctl4;
    logic [2*C-1:0]  r_hh;
    logic [2*C:0]    r_hl;
    logic [2*C+1:0]  r_ll;
    logic [MW-1:0]   r_den4, r_esq4;

    // ---------------- stage 5: squared numerator ----------------
    psd_pkg::t_ctl r_ctl5;
    logic [RW-1:0] r_rem5;
    logic [MW-1:0] r_den5;

    // The pipeline moves as a whole unless the output holds an untaken result.
    psd_pkg::t_ctl w_ctl [0:NST];
    logic [RW-1:0] w_rem [0:NST];
    logic [QDW-1:0] w_qd [0:NST];
    logic [MW-1:0] w_den [0:NST];
    logic [QW-1:0] w_q   [0:NST];

    assign w_en = !w_ctl[NST].vld || i_m_axis_tready;

    // Control of the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
        end else if (w_en) begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
        end
    end

    // Payload of the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= DW'(w_ex - w_sx);
            r_dy <= DW'(w_ey - w_sy);
            r_ox <= DW'(w_px - w_sx);
            r_oy <= DW'(w_py - w_sy);

            r_dyox <= PW'(r_dy * r_ox);
            r_dxoy <= PW'(r_dx * r_oy);
            r_dxdx <= PW'(r_dx * r_dx);
            r_dydy <= PW'(r_dy * r_dy);
            r_oxox <= PW'(r_ox * r_ox);
            r_oyoy <= PW'(r_oy * r_oy);

            r_mag  <= w_n[PW-1] ? MW'(-w_n) : MW'(w_n);
            r_den3 <= r_ctl2.degen ? MW'(1) : MW'(r_dxdx + r_dydy);
            r_esq3 <= MW'(r_oxox + r_oyoy);

            r_hh   <= (2*C)'(r_mag[MW-1:C+1] * r_mag[MW-1:C+1]);
            r_hl   <= (2*C+1)'(r_mag[MW-1:C+1] * r_mag[C:0]);
            r_ll   <= (2*C+2)'(r_mag[C:0] * r_mag[C:0]);
            r_den4 <= r_den3;
            r_esq4 <= r_esq3;

            r_rem5 <= r_ctl4.degen ? RW'(r_esq4) :
                      (RW'(r_hh) << (2*(C+1))) + (RW'(r_hl) << (C+2)) + RW'(r_ll);
            r_den5 <= r_den4;
        end
    end

    // ---------------- root stages, most significant bit first -----------
    assign w_ctl[0] = r_ctl5;
    assign w_rem[0] = r_rem5;
    assign w_qd[0]  = '0;
    assign w_den[0] = r_den5;
    assign w_q[0]   = '0;

    for (genvar g = 0; g < NST; g++) begin : g_root
        psd_root_stage #(
            .COORD_BITS (C),
            .BIT        (C - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_qd    (w_qd[g]),
            .i_den   (w_den[g]),
            .i_q     (w_q[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_qd    (w_qd[g+1]),
            .o_den   (w_den[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    // Output side: an outside point reports a zero distance.
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = w_ctl[NST].vld;
    assign o_m_axis_tuser  = w_ctl[NST].outside;
    assign o_m_axis_tdata  = w_ctl[NST].outside ? '0 : OUT_W'(w_q[NST]);

    // A held result must block new input transfers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

    // Nothing leaves the pipeline right after reset.
    assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result stays and keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-segment hit distance core testbench
// Drives point/segment transfers with random gaps and back-pressure, predicts
// the outside flag and the floored line distance with exact integer math, and
// compares every result in order. Several tolerance settings are exercised.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CB        = psd_pkg::COORD_BITS;
    localparam int DIST_BITS = CB + 1;
    localparam int LATENCY   = CB + 6;
    localparam int DOG_LIMIT = 5000;

    // One query: a point and a segment, all signed coordinates.
    typedef struct packed {
        logic signed [CB-1:0] end_y;
        logic signed [CB-1:0] end_x;
        logic signed [CB-1:0] start_y;
        logic signed [CB-1:0] start_x;
        logic signed [CB-1:0] point_y;
        logic signed [CB-1:0] point_x;
    } t_query;

    typedef struct packed {
        logic                 outside_box;
        logic [DIST_BITS-1:0] distance;
    } t_hit;

    logic                 i_clk;
    logic                 i_rst_n;
    logic [6*CB-1:0]      i_s_axis_tdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [23:0]          o_m_axis_tdata;
    logic                 o_m_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic                 i_cfg_we;
    logic [psd_pkg::TOL_BITS-1:0] i_cfg_wdata;

    // Testbench copy of the tolerance register.
    logic [psd_pkg::TOL_BITS-1:0] tolerance_model;
    t_hit                 pending_hits[$];
    int                   error_count;
    bit                   steady_send;
    bit                   steady_recv;
    int                   recv_hold;
    int                   idle_cycles;

    point_segment_hit_distance_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Exact hit prediction: box test, then largest q with q*q*den <= num.
    function automatic t_hit predict_hit(t_query qr, logic [psd_pkg::TOL_BITS-1:0] tol);
        longint px, py, sx, sy, ex, ey, tl, lo_x, hi_x, lo_y, hi_y, dx, dy, n;
        logic [127:0] num, den, t;
        logic [DIST_BITS-1:0] q;
        t_hit r;
        px = qr.point_x;  py = qr.point_y;
        sx = qr.start_x;  sy = qr.start_y;
        ex = qr.end_x;    ey = qr.end_y;
        tl = tol;
        lo_x = (sx < ex) ? sx : ex;  hi_x = (sx < ex) ? ex : sx;
        lo_y = (sy < ey) ? sy : ey;  hi_y = (sy < ey) ? ey : sy;
        r = '0;
        if (px < lo_x - tl || px > hi_x + tl || py < lo_y - tl || py > hi_y + tl) begin
            r.outside_box = 1'b1;
            return r;
        end
        if (sx == ex && sy == ey) begin
            num = 128'((px - sx) * (px - sx)) + 128'((py - sy) * (py - sy));
            den = 128'd1;
        end else begin
            dx  = ex - sx;
            dy  = ey - sy;
            n   = dy * (px - sx) - dx * (py - sy);
            if (n < 0) n = -n;
            num = 128'(n) * 128'(n);
            den = 128'(dx * dx) + 128'(dy * dy);
        end
        q = '0;
        for (int b = DIST_BITS - 1; b >= 0; b--) begin
            t = 128'(q | (DIST_BITS'(1) << b));
            if (t * t * den <= num) q = DIST_BITS'(t);
        end
        r.distance = q;
        return r;
    endfunction

    // Random coordinate in [lo, hi], clamped to the signed field range.
    function automatic logic signed [CB-1:0] coord_between(longint lo, longint hi);
        longint v;
        if (lo < -(1 <<< (CB - 1))) lo = -(1 <<< (CB - 1));
        if (hi > (1 <<< (CB - 1)) - 1) hi = (1 <<< (CB - 1)) - 1;
        v = lo + $urandom_range(0, int'(hi - lo));
        return CB'(v);
    endfunction

    // Sends one query, with random gaps unless steady sending is on.
    task automatic send_query(t_query qr);
        while (!steady_send && $urandom_range(0, 99) < 25) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= qr;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        pending_hits.push_back(predict_hit(qr, tolerance_model));
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Waits until every result is back and the pipeline is empty.
    task automatic drain_results();
        stop_sending();
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [psd_pkg::TOL_BITS-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        tolerance_model = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Segment-relative query: mostly inside the widened box.
    function automatic t_query random_query();
        t_query qr;
        longint tl, span, lo_x, hi_x, lo_y, hi_y;
        int kind;
        tl   = tolerance_model;
        kind = $urandom_range(0, 99);
        span = ($urandom_range(0, 3) == 0) ? 65535 : (1 << $urandom_range(1, 12));
        qr.start_x = coord_between(-32768, 32767);
        qr.start_y = coord_between(-32768, 32767);
        qr.end_x   = coord_between(longint'(qr.start_x) - span, longint'(qr.start_x) + span);
        qr.end_y   = coord_between(longint'(qr.start_y) - span, longint'(qr.start_y) + span);
        if (kind < 10) begin
            qr.end_x = qr.start_x;
            qr.end_y = qr.start_y;
        end else if (kind < 15) begin
            qr.end_x = qr.start_x;
        end else if (kind < 20) begin
            qr.end_y = qr.start_y;
        end
        lo_x = (qr.start_x < qr.end_x) ? qr.start_x : qr.end_x;
        hi_x = (qr.start_x < qr.end_x) ? qr.end_x : qr.start_x;
        lo_y = (qr.start_y < qr.end_y) ? qr.start_y : qr.end_y;
        hi_y = (qr.start_y < qr.end_y) ? qr.end_y : qr.start_y;
        if (kind < 80) begin
            qr.point_x = coord_between(lo_x - tl, hi_x + tl);
            qr.point_y = coord_between(lo_y - tl, hi_y + tl);
        end else if (kind < 90) begin
            // Just around the box edge, on either side of it.
            qr.point_x = coord_between(lo_x - tl - 2, lo_x - tl + 1);
            qr.point_y = coord_between(hi_y + tl - 1, hi_y + tl + 2);
            if ($urandom_range(0, 1)) qr.point_x = coord_between(hi_x + tl - 1, hi_x + tl + 2);
        end else begin
            qr.point_x = coord_between(-32768, 32767);
            qr.point_y = coord_between(-32768, 32767);
        end
        return qr;
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) send_query(random_query());
    endtask

    // Field extremes, degenerate segments and the box edges.
    task automatic test_directed();
        localparam logic signed [CB-1:0] MX = {1'b0, {(CB-1){1'b1}}};
        localparam logic signed [CB-1:0] MN = {1'b1, {(CB-1){1'b0}}};
        send_query('{MX, MX, MN, MN, MN, MX});
        send_query('{MX, MX, MN, MN, MX, MN});
        send_query('{MX, MN, MN, MX, 16'sd0, 16'sd0});
        send_query('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd4});
        send_query('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_query('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd0});
        send_query('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4, -16'sd4});
        send_query('{MX, MX, MX, MX, MX, MX});
        send_query('{MN, MN, MN, MN, MN, MN});
        send_query('{MN, MN, MN, MN, MN + 16'sd3, MN + 16'sd4});
        send_query('{16'sd10, 16'sd100, 16'sd0, 16'sd0, 16'sd5, -16'sd4});
        send_query('{16'sd10, 16'sd100, 16'sd0, 16'sd0, 16'sd5, -16'sd5});
        send_query('{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd104, 16'sd2});
        send_query('{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd105, 16'sd2});
        send_query('{MN, MN, MX, MX, 16'sd1, -16'sd1});
        send_query('{MX, MN, MN, MX, MX, MX});
        send_query('{16'sd7, 16'sd3, -16'sd9, -16'sd2, 16'sd1, 16'sd1});
    endtask

    task automatic test_tolerance_settings();
        write_tolerance('0);
        test_directed();
        send_random(150);
        write_tolerance('1);
        test_directed();
        send_random(150);
        write_tolerance(psd_pkg::TOL_BITS'(1));
        send_random(100);
        write_tolerance(psd_pkg::TOL_BITS'($urandom_range(0, (1 << psd_pkg::TOL_BITS) - 1)));
        send_random(150);
    endtask

    task automatic test_streaming();
        steady_send = 1'b1;
        steady_recv = 1'b1;
        send_random(300);
        steady_send = 1'b0;
        steady_recv = 1'b0;
        send_random(300);
    endtask

    // Receiver holds off long enough to fill the pipeline and stall the input.
    task automatic test_backpressure();
        steady_send = 1'b1;
        recv_hold   = 200;
        send_random(150);
        steady_send = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        send_random(40);
        drain_results();
        send_random(40);
    endtask

    // Receiver ready: random idling, steady mode or a counted hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            recv_hold       <= recv_hold - 1;
        end else if (steady_recv) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // Result checker: each transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected result: outside_box %0b distance %0d",
                       o_m_axis_tuser, o_m_axis_tdata[DIST_BITS-1:0]);
                error_count++;
            end else begin
                want = pending_hits.pop_front();
                if (o_m_axis_tuser !== want.outside_box) begin
                    $error("outside_box expected %0b actual %0b",
                           want.outside_box, o_m_axis_tuser);
                    error_count++;
                end
                if (o_m_axis_tdata[DIST_BITS-1:0] !== want.distance) begin
                    $error("distance expected %0d actual %0d",
                           want.distance, o_m_axis_tdata[DIST_BITS-1:0]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= DOG_LIMIT) begin
            $display("point_segment_hit_distance_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_m_axis_tready = 1'b0;
        tolerance_model = psd_pkg::TOL_RESET;
        error_count     = 0;
        steady_send     = 1'b0;
        steady_recv     = 1'b0;
        recv_hold       = 0;
        idle_cycles     = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_tolerance_settings();
        test_streaming();
        test_backpressure();
        test_pause_until_drained();
        drain_results();

        if (error_count == 0) begin
            $display("point_segment_hit_distance_core regression: pass");
        end else begin
            $display("point_segment_hit_distance_core regression: fail");
        end
        $finish;
    end

endmodule
